// ===== src/rsort_pkg.sv =====
// Package for the record insertion sorter.
// Beat types, stored record type and cell control; no dependencies.

package rsort_pkg;

  localparam int DEPTH_DEF = 64;

  typedef struct packed {
    logic [13:0] year;
    logic [8:0]  day_of_year;
    logic [31:0] money_bits;
    logic [31:0] hours_bits;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        last;
  } in_beat_t;

  typedef struct packed {
    logic [13:0] out_year;
    logic [8:0]  out_day_of_year;
    logic [31:0] out_money_bits;
    logic [31:0] out_hours_bits;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic        out_last;
    logic        out_overflow;
  } out_beat_t;

  typedef struct packed {
    logic [13:0] year;
    logic [8:0]  day_of_year;
    logic [31:0] money_bits;
    logic [31:0] hours_bits;
    logic [3:0]  month;
    logic [4:0]  day;
  } rec_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } ctrl_t;

endpackage

// ===== src/rsort_cell.sv =====
// One slot of the sorting chain: holds a record, compares it with the
// arriving one, and passes records to its neighbors. Uses rsort_pkg.

module rsort_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic           clk,
  input  rsort_pkg::ctrl_t ctrl,
  input  logic [CW-1:0]  count,
  input  rsort_pkg::rec_t new_rec,
  input  logic           prev_gt,
  input  rsort_pkg::rec_t prev_rec,
  input  rsort_pkg::rec_t next_rec,
  output logic           gt,
  output rsort_pkg::rec_t rec
);
  import rsort_pkg::*;

  logic occupied;

  assign occupied = CW'(IDX) < count;
  assign gt = !occupied ||
              ({rec.year, rec.day_of_year} > {new_rec.year, new_rec.day_of_year});

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      rec <= next_rec;
    end else if (ctrl.ins && gt) begin
      rec <= prev_gt ? prev_rec : new_rec;
    end
  end

endmodule

// ===== src/record_insertion_sorter_top.sv =====
// Top level of the record insertion sorter: cell chain, fill count,
// drain sequencer and output register. Uses rsort_pkg and rsort_cell.
//
//  channel | direction | payload    | flow
//  in      | input     | in_beat_t  | in_valid / in_stall
//  out     | output    | out_beat_t | out_valid / out_stall
//
// A record without last is taken while in_stall is low; records may follow back to back.
// A record with last is inserted unless the chain is full, then the chain
// shifts one record a cycle toward the output register while the output is
// not stalled. in_stall is high for the whole drain. Output stalls hold the
// chain. Reset empties the chain at once.

module record_insertion_sorter_top #(
  parameter int DEPTH = rsort_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rsort_pkg::in_beat_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rsort_pkg::out_beat_t out_data
);
  import rsort_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] remaining;
  logic          dropped;
  logic          draining;
  logic          drain_ovf;
  logic          accept;
  logic          full;
  logic          load;
  ctrl_t         ctrl;
  rec_t          new_rec;
  logic          gt_chain  [DEPTH];
  rec_t          rec_chain [DEPTH];

  assign in_stall = draining;
  assign accept   = in_valid && !draining;
  assign full     = count == CW'(DEPTH);
  assign load     = draining && (!out_valid || !out_stall);

  assign ctrl.ins   = accept && !full;
  assign ctrl.shift = load;

  assign new_rec.year        = in_data.year;
  assign new_rec.day_of_year = in_data.day_of_year;
  assign new_rec.money_bits  = in_data.money_bits;
  assign new_rec.hours_bits  = in_data.hours_bits;
  assign new_rec.month       = in_data.month;
  assign new_rec.day         = in_data.day;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic prev_gt;
    rec_t prev_rec;
    rec_t next_rec;

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_rec = '0;
    end else begin : g_mid
      assign prev_gt  = gt_chain[i-1];
      assign prev_rec = rec_chain[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_rec = '0;
    end else begin : g_link
      assign next_rec = rec_chain[i+1];
    end

    rsort_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .count   (count),
      .new_rec (new_rec),
      .prev_gt (prev_gt),
      .prev_rec(prev_rec),
      .next_rec(next_rec),
      .gt      (gt_chain[i]),
      .rec     (rec_chain[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      draining  <= 1'b0;
      drain_ovf <= 1'b0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (in_data.last) begin
          draining  <= 1'b1;
          remaining <= full ? count : count + CW'(1);
          drain_ovf <= dropped || full;
          count     <= '0;
          dropped   <= 1'b0;
        end else if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (load) begin
        out_valid <= 1'b1;
        remaining <= remaining - CW'(1);
        if (remaining == CW'(1)) begin
          draining <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_year        <= rec_chain[0].year;
      out_data.out_day_of_year <= rec_chain[0].day_of_year;
      out_data.out_money_bits  <= rec_chain[0].money_bits;
      out_data.out_hours_bits  <= rec_chain[0].hours_bits;
      out_data.out_month       <= rec_chain[0].month;
      out_data.out_day         <= rec_chain[0].day;
      out_data.out_last        <= remaining == CW'(1);
      out_data.out_overflow    <= drain_ovf;
    end
  end

endmodule

// ===== src/rsort_checker.sv =====
// Port-level checks for the record insertion sorter, bound to the top.
// Uses rsort_pkg and sees record_insertion_sorter_top ports only.

module rsort_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input rsort_pkg::in_beat_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input rsort_pkg::out_beat_t out_data
);
  import rsort_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_reset_open: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("no drain after last beat");

  a_idle_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_stall |-> out_data.out_last)
    else $error("pending beat outside a drain is not final");

  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.out_last |=>
      !out_valid || (out_data.out_overflow == $past(out_data.out_overflow)))
    else $error("overflow flag changed within a run");

endmodule

bind record_insertion_sorter_top rsort_checker u_rsort_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
